// File: rtl/core/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types and constants for the boxcar moving average block: item
// layouts, register and status codes, controller states, command/status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bma_pkg;

    // Sample width is fixed by the item format
    localparam int SAMPLE_BITS = 24;

    // Register indexes
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    // Averaging modes
    localparam logic [1:0] MODE_MEAN    = 2'd0;
    localparam logic [1:0] MODE_ERRPROP = 2'd1;
    localparam logic [1:0] MODE_RMS     = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    // Reset value of the window register
    localparam logic [5:0] WINDOW_RESET = 6'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_missing;
        logic                          final_sample;
    } smp_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic [1:0]                    status;
        logic                          final_result;
    } res_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SQ,
        ST_SUB,
        ST_ADD_SQ,
        ST_ADD,
        ST_CALC,
        ST_OPA,
        ST_WAITA,
        ST_OPB,
        ST_WAITB,
        ST_OUT,
        ST_FL_INIT
    } bma_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic rd;
        logic sq;
        logic sub;
        logic add_sq;
        logic add;
        logic acc_load;
        logic div_start;
        logic sqrt_start;
        logic out_load;
        logic fl_init;
        logic fl_next;
        logic clear_seq;
        logic flush;
    } bma_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic prev_ge_w;
        logic prev_ge_h;
        logic fin;
        logic fl_sub_ok;
        logic fl_last;
        logic valid_zero;
        logic div_done;
        logic sqrt_done;
        logic out_free;
        logic mode_errprop;
        logic mode_rms;
    } bma_status_t;

endpackage

// File: rtl/core/bma_divider.sv
// ----------------------------------------------------------------------------
// bma_divider
// Restoring unsigned divider, one quotient bit per cycle. Pulses done for
// one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module bma_divider #(
    parameter int N = 53,
    parameter int D = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  q_reg;
    logic [D:0]    rem_reg;
    logic [D-1:0]  div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [D:0]    trial;
    logic          fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg[D-1:0], q_reg[N-1]};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, div_reg}) : trial;
            q_reg   <= {q_reg[N-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/core/bma_isqrt.sv
// ----------------------------------------------------------------------------
// bma_isqrt
// Floor square root, digit by digit, one result bit per cycle. Pulses done
// for one cycle when the root is ready.
// ----------------------------------------------------------------------------
module bma_isqrt #(
    parameter int N = 53
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] radicand,
    output logic         done,
    output logic [N-1:0] root
);

    // Work on an even width so the probe bit starts on an even position
    localparam int SW = N + (N % 2);

    logic [SW-1:0] x_reg;
    logic [SW-1:0] res_reg;
    logic [SW-1:0] bit_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] probe;
    logic          take;

    always_comb
    begin
        probe = res_reg + bit_reg;
        take  = (x_reg >= probe);
    end

    // Control: busy until the probe bit has reached bit zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: remainder, partial root, probe bit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= SW'(radicand);
            res_reg <= '0;
            bit_reg <= SW'(1) << (SW - 2);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                x_reg   <= x_reg - probe;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = N'(res_reg);

endmodule

// File: rtl/core/bma_datapath.sv
// ----------------------------------------------------------------------------
// bma_datapath
// Sample history memory, running total and counts, term squarer, divider
// and square root units, result formatting and the output register.
// ----------------------------------------------------------------------------
module bma_datapath #(
    parameter int MAX_WINDOW = 63,
    parameter int CNT_W      = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CNT_W-1:0]      win,
    input  logic [1:0]            mode,
    input  logic                  cfg_clear,
    input  bma_pkg::bma_cmd_t     cmd,
    output bma_pkg::bma_status_t  st,
    input  bma_pkg::smp_item_t    smp_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output bma_pkg::res_item_t    res_data
);

    import bma_pkg::*;

    localparam int DEPTH  = MAX_WINDOW + 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int SB     = SAMPLE_BITS;
    localparam int TOT_RQ = 2 * SB + CNT_W;
    localparam int TOT_W  = (TOT_RQ > 64) ? 64 : TOT_RQ;

    // History memory: sample with its missing bit on top
    logic [SB:0]          mem [DEPTH];
    logic [SB:0]          rd_data_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     ptr_next;
    logic [PTR_W-1:0]     rd_addr;
    logic [CNT_W-1:0]     rd_age;
    logic [PTR_W:0]       wrap_sum;

    smp_item_t            in_reg;
    logic [CNT_W-1:0]     prev_seen_reg;
    logic [CNT_W-1:0]     seen_reg;
    logic [CNT_W-1:0]     valid_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [TOT_W-1:0]     total_reg;
    logic [TOT_W-1:0]     term_reg;
    logic                 term_miss_reg;
    logic [TOT_W-1:0]     acc_reg;
    logic                 neg_reg;

    logic [CNT_W-1:0]     half;
    logic                 squaring;
    logic signed [SB-1:0] term_src;
    logic [SB-1:0]        term_mag;
    logic [2*SB-1:0]      term_sq;
    logic [TOT_W-1:0]     term_val;
    logic [TOT_W-1:0]     total_abs;
    logic [CNT_W:0]       fl_need;

    logic                 div_done;
    logic [TOT_W-1:0]     div_q;
    logic                 sqrt_done;
    logic [TOT_W-1:0]     sqrt_r;

    res_item_t            res_reg;
    logic                 res_valid_reg;
    res_item_t            res_new;
    logic                 last_result;
    logic [SB-1:0]        q_low;

    // Half window and mode decode
    always_comb
    begin
        half     = (win - 1'b1) >> 1;
        squaring = (mode == MODE_ERRPROP) || (mode == MODE_RMS);
    end

    // Address of a given age behind the newest sample
    always_comb
    begin
        rd_age   = cmd.flush ? (half + rem_reg) : (win - 1'b1);
        wrap_sum = {1'b0, ptr_reg} + (PTR_W + 1)'(DEPTH) - (PTR_W + 1)'(rd_age);
        if (ptr_reg >= PTR_W'(rd_age))
            rd_addr = ptr_reg - PTR_W'(rd_age);
        else
            rd_addr = wrap_sum[PTR_W-1:0];
        ptr_next = (ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    end

    // Write the new sample, read one aged sample
    always_ff @(posedge clk)
    begin
        if (cmd.add_sq)
            mem[ptr_next] <= {in_reg.sample_missing, in_reg.sample};
        if (cmd.rd)
            rd_data_reg <= mem[rd_addr];
    end

    // Term of a sample: the value itself or its square
    always_comb
    begin
        term_src = cmd.add_sq ? in_reg.sample : $signed(rd_data_reg[SB-1:0]);
        term_mag = term_src[SB-1] ? SB'(-term_src) : SB'(term_src);
        term_sq  = term_mag * term_mag;
        term_val = squaring ? TOT_W'(term_sq) : TOT_W'(term_src);
    end

    // Magnitude of the signed total for the mean
    always_comb
    begin
        total_abs = total_reg[TOT_W-1] ? (~total_reg + 1'b1) : total_reg;
        fl_need   = {1'b0, half} + {1'b0, rem_reg} + 1'b1;
    end

    // Write pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else if (cmd.add_sq)
            ptr_reg <= ptr_next;
    end

    // Sequence state: total, counts, flush position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            valid_reg <= '0;
            seen_reg  <= '0;
            rem_reg   <= '0;
        end
        else if (cfg_clear || cmd.clear_seq)
        begin
            total_reg <= '0;
            valid_reg <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            if (cmd.sub && !term_miss_reg)
            begin
                total_reg <= total_reg - term_reg;
                if (valid_reg != '0)
                    valid_reg <= valid_reg - 1'b1;
            end
            if (cmd.add)
            begin
                if (!term_miss_reg)
                begin
                    total_reg <= total_reg + term_reg;
                    valid_reg <= valid_reg + 1'b1;
                end
                if (seen_reg < win)
                    seen_reg <= seen_reg + 1'b1;
            end
            if (cmd.fl_init)
                rem_reg <= (seen_reg < half) ? seen_reg : half;
            else if (cmd.fl_next)
                rem_reg <= rem_reg - 1'b1;
        end
    end

    // Accepted item, term and working accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_reg        <= smp_data;
            prev_seen_reg <= seen_reg;
        end
        if (cmd.sq || cmd.add_sq)
        begin
            term_reg      <= term_val;
            term_miss_reg <= cmd.add_sq ? in_reg.sample_missing : rd_data_reg[SB];
        end
        if (cmd.acc_load)
        begin
            acc_reg <= squaring ? total_reg : total_abs;
            neg_reg <= !squaring && total_reg[TOT_W-1];
        end
        else if (div_done)
            acc_reg <= div_q;
        else if (sqrt_done)
            acc_reg <= sqrt_r;
    end

    bma_divider #(
        .N (TOT_W),
        .D (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (valid_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    bma_isqrt #(
        .N (TOT_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg),
        .done     (sqrt_done),
        .root     (sqrt_r)
    );

    // Format the result: sign, saturation, status, end of sequence
    always_comb
    begin
        last_result = cmd.flush && (rem_reg == CNT_W'(1));
        q_low       = acc_reg[SB-1:0];
        res_new     = '0;
        if (valid_reg == '0)
        begin
            res_new.smoothed = '0;
            res_new.status   = STATUS_EMPTY;
        end
        else
        begin
            res_new.status = STATUS_OK;
            if (!squaring)
                res_new.smoothed = neg_reg ? $signed(-q_low) : $signed(q_low);
            else if (acc_reg > TOT_W'((1 << (SB - 1)) - 1))
                res_new.smoothed = $signed(SB'((1 << (SB - 1)) - 1));
            else
                res_new.smoothed = $signed(q_low);
        end
        if (last_result)
        begin
            res_new.final_result = 1'b1;
            if (seen_reg < win)
                res_new.status = STATUS_SHORT;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.out_load)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            res_reg <= res_new;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Status to the controller
    always_comb
    begin
        st.prev_ge_w    = (prev_seen_reg >= win);
        st.prev_ge_h    = (prev_seen_reg >= half);
        st.fin          = in_reg.final_sample;
        st.fl_sub_ok    = ({1'b0, seen_reg} >= fl_need);
        st.fl_last      = (rem_reg == CNT_W'(1));
        st.valid_zero   = (valid_reg == '0);
        st.div_done     = div_done;
        st.sqrt_done    = sqrt_done;
        st.out_free     = !res_valid_reg || res_ready;
        st.mode_errprop = (mode == MODE_ERRPROP);
        st.mode_rms     = (mode == MODE_RMS);
    end

endmodule

// File: rtl/core/bma_ctrl.sv
// ----------------------------------------------------------------------------
// bma_ctrl
// Sequencer: takes an item, retires the oldest window sample, adds the new
// one, runs the divide / square root steps per result and walks the flush.
// ----------------------------------------------------------------------------
module bma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 smp_valid,
    output logic                 smp_ready,
    input  bma_pkg::bma_status_t st,
    output bma_pkg::bma_cmd_t    cmd
);

    import bma_pkg::*;

    bma_state_t state_reg;
    bma_state_t state_next;
    logic       flush_reg;
    logic       flush_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        cmd        = '0;
        cmd.flush  = flush_reg;
        smp_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                smp_ready = 1'b1;
                if (smp_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.sub    = flush_reg ? st.fl_sub_ok : st.prev_ge_w;
                state_next = flush_reg ? ST_CALC : ST_ADD_SQ;
            end
            ST_ADD_SQ:
            begin
                cmd.add_sq = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                if (st.prev_ge_h)
                    state_next = ST_CALC;
                else if (st.fin)
                    state_next = ST_FL_INIT;
                else
                    state_next = ST_IDLE;
            end
            ST_CALC:
            begin
                if (st.valid_zero)
                    state_next = ST_OUT;
                else
                begin
                    cmd.acc_load = 1'b1;
                    state_next   = ST_OPA;
                end
            end
            ST_OPA:
            begin
                cmd.sqrt_start = st.mode_errprop;
                cmd.div_start  = !st.mode_errprop;
                state_next     = ST_WAITA;
            end
            ST_WAITA:
            begin
                if (st.mode_errprop ? st.sqrt_done : st.div_done)
                    state_next = (st.mode_errprop || st.mode_rms) ? ST_OPB : ST_OUT;
            end
            ST_OPB:
            begin
                cmd.div_start  = st.mode_errprop;
                cmd.sqrt_start = !st.mode_errprop;
                state_next     = ST_WAITB;
            end
            ST_WAITB:
            begin
                if (st.mode_errprop ? st.div_done : st.sqrt_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (flush_reg)
                    begin
                        if (st.fl_last)
                        begin
                            cmd.clear_seq = 1'b1;
                            flush_next    = 1'b0;
                            state_next    = ST_IDLE;
                        end
                        else
                        begin
                            cmd.fl_next = 1'b1;
                            state_next  = ST_RD;
                        end
                    end
                    else if (st.fin)
                        state_next = ST_FL_INIT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_FL_INIT:
            begin
                cmd.fl_init = 1'b1;
                flush_next  = 1'b1;
                state_next  = ST_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
                flush_next = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/boxcar_moving_average.sv
// ----------------------------------------------------------------------------
// boxcar_moving_average
// Centered odd-width moving average with missing-sample skipping and three
// averaging modes (mean, error propagation, root mean square).
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  smp       in         smp_valid / smp_ready   smp_item_t
//  res       out        res_valid / res_ready   res_item_t
//  apb       in/out     psel, penable, pready   window_points, average_mode
//
//  An item enters the window through the read, square, subtract, add-square
//  and add states. Per result the mean mode runs a divide and the other
//  modes a divide and a square root over T bits, T being the running total
//  width (54 at the default window); each unit resolves one bit per cycle.
//  A final item adds up to (window-1)/2 flush results, each of which may
//  retire an aged sample. Reset clears the sequence state; the history
//  memory needs no clearing. A stalled result holds the output register
//  and the sequencer, and no new item is taken until its results are out.
// ----------------------------------------------------------------------------
module boxcar_moving_average #(
    parameter int MAX_WINDOW = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                smp_valid,
    output logic                smp_ready,
    input  bma_pkg::smp_item_t  smp_data,
    output logic                res_valid,
    input  logic                res_ready,
    output bma_pkg::res_item_t  res_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import bma_pkg::*;

    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int TOP_WIN = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;

    logic [5:0]       window_points_reg;
    logic [1:0]       average_mode_reg;
    logic             cfg_wr;
    logic [6:0]       win_raw;
    logic [6:0]       win_eff;
    bma_cmd_t         cmd;
    bma_status_t      st;

    // Register writes on the access phase
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_points_reg <= WINDOW_RESET;
            average_mode_reg  <= MODE_MEAN;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_WINDOW)
                window_points_reg <= pwdata[5:0];
            else
                average_mode_reg <= pwdata[1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_WINDOW)
            prdata = {26'd0, window_points_reg};
        else
            prdata = {30'd0, average_mode_reg};
    end

    // Round the window down to odd and clamp it to the supported range
    always_comb
    begin
        win_raw = {1'b0, window_points_reg};
        if (!win_raw[0] && (win_raw != 7'd0))
            win_raw = win_raw - 1'b1;
        win_eff = win_raw;
        if (win_raw < 7'd3)
            win_eff = 7'd3;
        else if (win_raw > 7'(TOP_WIN))
            win_eff = 7'(TOP_WIN);
    end

    bma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .st        (st),
        .cmd       (cmd)
    );

    bma_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .CNT_W      (CNT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (CNT_W'(win_eff)),
        .mode      (average_mode_reg),
        .cfg_clear (cfg_wr),
        .cmd       (cmd),
        .st        (st),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

// File: rtl/core/bma_checker.sv
// ----------------------------------------------------------------------------
// bma_checker
// Port-level checks on the result channel and the register port.
// ----------------------------------------------------------------------------
module bma_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input bma_pkg::res_item_t res_data,
    input logic               pready
);

    import bma_pkg::*;

    // No result shows while reset is applied
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("stalled result changed");

    // Short-sequence status only on the last result
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.status == STATUS_SHORT)) |-> res_data.final_result)
        else $error("short status on a non-final result");

    // An empty window gives zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_data.status == STATUS_EMPTY)) |-> (res_data.smoothed == '0))
        else $error("empty window with nonzero value");

    // Register port never waits
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind boxcar_moving_average bma_checker u_bma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .pready    (pready)
);

// File: verif/boxcar_moving_average_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boxcar_moving_average_checker
// Watches the sample, result and register ports of the moving average block,
// keeps its own copy of the window state, works out the results each sample
// item causes and compares every result item field by field, in order.
// ----------------------------------------------------------------------------
module boxcar_moving_average_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               smp_valid,
    input  logic               smp_ready,
    input  bma_pkg::smp_item_t smp_data,
    input  logic               res_valid,
    input  logic               res_ready,
    input  bma_pkg::res_item_t res_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    import bma_pkg::*;

    localparam int DEPTH = 64;

    // Mirror of the registers and the window state
    logic [5:0]  win_reg;
    logic [1:0]  mode_reg;
    logic [24:0] hist [DEPTH];
    logic [63:0] total;
    int unsigned vcnt;
    int unsigned seen;
    res_item_t   smoothed_q[$];

    function automatic int unsigned eff_window();
        int unsigned w;
        w = win_reg;
        if (w % 2 == 0 && w > 0)
            w--;
        if (w < 3)
            w = 3;
        if (w > 63)
            w = 63;
        return w;
    endfunction

    // Squared magnitude in the root modes, sign-extended value otherwise
    function automatic logic [63:0] term_of(logic [24:0] p);
        logic signed [23:0] s;
        logic [63:0]        m;
        s = p[23:0];
        if (mode_reg == MODE_ERRPROP || mode_reg == MODE_RMS)
        begin
            m = (s < 0) ? 64'(-64'(s)) : 64'(s);
            return m * m;
        end
        return 64'(signed'(s));
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [23:0] window_average();
        logic [63:0]        r;
        logic signed [63:0] q;
        if (mode_reg == MODE_ERRPROP)
            r = floor_sqrt(total) / 64'(vcnt);
        else if (mode_reg == MODE_RMS)
            r = floor_sqrt(total / 64'(vcnt));
        else
        begin
            q = $signed(total) / $signed(64'(vcnt));
            if (q > 64'sd8388607)
                q = 64'sd8388607;
            if (q < -64'sd8388608)
                q = -64'sd8388608;
            return q[23:0];
        end
        if (r > 64'd8388607)
            r = 64'd8388607;
        return r[23:0];
    endfunction

    function automatic void drop_age(int unsigned age);
        logic [24:0] p;
        p = hist[age % DEPTH];
        if (!p[24])
        begin
            total = total - term_of(p);
            if (vcnt > 0)
                vcnt--;
        end
    endfunction

    function automatic void push_result();
        res_item_t r;
        r.final_result = 1'b0;
        r.status       = STATUS_OK;
        r.smoothed     = '0;
        if (vcnt == 0)
            r.status = STATUS_EMPTY;
        else
            r.smoothed = window_average();
        smoothed_q.push_back(r);
    endfunction

    function automatic void clear_sequence();
        total = 0;
        vcnt  = 0;
        seen  = 0;
    endfunction

    // Advance the window by one sample item and queue the results it causes
    function automatic void take_sample(smp_item_t it);
        int unsigned w;
        int unsigned h;
        int unsigned prev;
        int unsigned n;
        int unsigned k;
        int          made;
        logic [24:0] p;
        w    = eff_window();
        h    = (w - 1) / 2;
        prev = seen;
        made = 0;
        p    = {it.sample_missing, it.sample};
        if (prev >= w)
            drop_age(w - 1);
        for (int a = DEPTH - 1; a > 0; a--)
            hist[a] = hist[a-1];
        hist[0] = p;
        if (!p[24])
        begin
            total = total + term_of(p);
            vcnt++;
        end
        if (prev < w)
            seen = prev + 1;
        if (prev >= h)
        begin
            push_result();
            made++;
        end
        if (it.final_sample)
        begin
            n = seen;
            k = (n > h) ? n - h : 0;
            for (; k < n; k++)
            begin
                if (k >= h + 1)
                    drop_age(n + h - k);
                push_result();
                made++;
            end
            if (made > 0)
            begin
                if (n < w)
                    smoothed_q[$].status = STATUS_SHORT;
                smoothed_q[$].final_result = 1'b1;
            end
            clear_sequence();
        end
    endfunction

    // Compare results, then register writes, then new sample items
    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            win_reg  = WINDOW_RESET;
            mode_reg = MODE_MEAN;
            clear_sequence();
            smoothed_q.delete();
            errors  <= 0;
            checked <= 0;
            pending <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (smoothed_q.size() == 0)
                begin
                    $display("%0t: unexpected result item smoothed=%0d status=%0d final=%0b",
                             $time, res_data.smoothed, res_data.status,
                             res_data.final_result);
                    errors <= errors + 1;
                end
                else
                begin
                    want = smoothed_q.pop_front();
                    if (want !== res_data)
                    begin
                        $display("%0t: mismatch expected smoothed=%0d status=%0d final=%0b",
                                 $time, want.smoothed, want.status, want.final_result);
                        $display("%0t:          actual   smoothed=%0d status=%0d final=%0b",
                                 $time, res_data.smoothed, res_data.status,
                                 res_data.final_result);
                        errors <= errors + 1;
                    end
                    checked <= checked + 1;
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == 3'(REG_WINDOW) * 3'd4)
                begin
                    win_reg = pwdata[5:0];
                    clear_sequence();
                end
                else if (paddr == 3'(REG_MODE) * 3'd4)
                begin
                    mode_reg = pwdata[1:0];
                    clear_sequence();
                end
            end
            if (smp_valid && smp_ready)
                take_sample(smp_data);
            pending <= smoothed_q.size();
        end
    end

endmodule

// File: verif/boxcar_moving_average_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boxcar_moving_average_test
// Drives the moving average block with directed and random sample sequences
// under changing window and mode settings, with random gaps on the sample
// side and random stalls on the result side; the checker does the scoring.
// ----------------------------------------------------------------------------
module boxcar_moving_average_test;
    import bma_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        smp_valid = 1'b0;
    logic        smp_ready;
    smp_item_t   smp_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_item_t   res_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int   errors;
    int   pending;
    int   checked;
    int   items_sent = 0;
    int   idle_cycles = 0;
    logic smp_taken = 1'b0;
    logic res_taken = 1'b0;
    logic calm = 1'b0;

    always #4 clk = ~clk;

    boxcar_moving_average uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    boxcar_moving_average_checker u_scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    // Capture handshakes at the edge so the drivers see them at the next fall
    always @(posedge clk)
    begin
        smp_taken <= smp_valid && smp_ready;
        res_taken <= res_valid && res_ready;
    end

    // Watchdog: end the run after too long without any item moving
    always @(posedge clk)
    begin
        if ((smp_valid && smp_ready) || (res_valid && res_ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: a random stall before each item, none in calm phases
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            do
                @(negedge clk);
            while (!res_taken);
        end
    end

    // Send one sample item after a random gap and hold it until taken
    task automatic send_sample(logic signed [23:0] value, logic miss, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            smp_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        smp_data  <= '{sample: value, sample_missing: miss, final_sample: last};
        smp_valid <= 1'b1;
        do
            @(negedge clk);
        while (!smp_taken);
        items_sent++;
    endtask

    // Hold off until every expected result is out and the block has settled
    task automatic drain();
        smp_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write: setup phase, then access phase
    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx) * 3'd4;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window_mode(logic [5:0] win, logic [1:0] mode);
        drain();
        write_reg(REG_WINDOW, 32'(win));
        write_reg(REG_MODE, 32'(mode));
    endtask

    // One random sequence; the value style and the missing rate vary per call
    task automatic random_sequence(int len);
        int                 style;
        int                 miss_pct;
        logic signed [23:0] value;
        style    = $urandom_range(0, 3);
        miss_pct = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(0, 3) * 10;
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0: value = 24'($urandom);
                1: value = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
                2: value = 24'($signed($urandom_range(0, 200)) - 100);
                default: value = $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                           : 24'($urandom_range(0, 4095));
            endcase
            send_sample(value, $urandom_range(1, 100) <= miss_pct, i == len - 1);
        end
    endtask

    initial
    begin
        int          w;
        logic [5:0]  win;
        int          phases;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, missing samples, short and empty sequences
        set_window_mode(6'd3, MODE_MEAN);
        send_sample(24'sh7fffff, 1'b0, 1'b0);
        send_sample(24'sh800000, 1'b0, 1'b0);
        send_sample(24'sd5, 1'b1, 1'b0);
        send_sample(-24'sd7, 1'b0, 1'b1);
        send_sample(24'sd100, 1'b0, 1'b1);
        send_sample(24'sd0, 1'b1, 1'b0);
        send_sample(24'sd0, 1'b1, 1'b0);
        send_sample(24'sd0, 1'b1, 1'b1);
        // Lone most negative sample saturates in the root modes
        set_window_mode(6'd3, MODE_ERRPROP);
        send_sample(24'sh800000, 1'b0, 1'b1);
        set_window_mode(6'd3, MODE_RMS);
        send_sample(24'sh800000, 1'b0, 1'b0);
        send_sample(24'sh7fffff, 1'b0, 1'b0);
        send_sample(24'sd3, 1'b0, 1'b1);
        // Unused mode and an even window
        set_window_mode(6'd4, 2'd3);
        send_sample(-24'sd9, 1'b0, 1'b0);
        send_sample(24'sd4, 1'b0, 1'b0);
        send_sample(24'sd11, 1'b1, 1'b0);
        send_sample(24'sd2, 1'b0, 1'b1);
        // Register write in the middle of a sequence drops it
        set_window_mode(6'd7, MODE_MEAN);
        send_sample(24'sd50, 1'b0, 1'b0);
        send_sample(-24'sd20, 1'b0, 1'b0);
        send_sample(24'sd1, 1'b0, 1'b0);
        set_window_mode(6'd7, MODE_ERRPROP);
        send_sample(24'sd6, 1'b0, 1'b0);
        send_sample(-24'sd8, 1'b0, 1'b1);

        // Random phases of settings and sequences
        phases = 0;
        while (items_sent < 220)
        begin
            case ($urandom_range(0, 5))
                0: win = 6'($urandom_range(0, 2));
                1: win = $urandom_range(0, 1) ? 6'd63 : 6'd62;
                default: win = 6'($urandom_range(3, 15));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            set_window_mode(win, 2'($urandom_range(0, 3)));
            w = (win < 3) ? 3 : int'(win);
            for (int s = $urandom_range(1, 3); s > 0; s--)
            begin
                if (win >= 62)
                    random_sequence($urandom_range(1, 3) == 1 ? $urandom_range(1, 10)
                                                              : $urandom_range(60, 70));
                else
                    random_sequence($urandom_range(1, w + 6));
            end
            phases++;
        end

        calm = 1'b0;
        drain();
        $display("Sent %0d sample items over %0d random setting phases plus directed cases;",
                 items_sent, phases);
        $display("checked %0d result items across windows 3..63 and all four mode codes.",
                 checked);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
